// ===== src/rhsl_pkg.sv =====
// Shared types and constants for the RGB to HSL converter.
// Used by the front stage, the item queue, the divider pipeline and the top level.
package rhsl_pkg;

    localparam logic [14:0] HUE_FULL  = 15'd23040;
    localparam logic [15:0] SAT_MAX   = 16'hFFFF;
    localparam int          HUE_STEPS = 15;
    localparam int          SAT_STEPS = 17;
    localparam int          STAGES    = SAT_STEPS + 1;

    typedef struct packed {
        logic [7:0]  d;
        logic [8:0]  sum;
        logic [7:0]  div;
        logic [10:0] num;
    } rhsl_work_t;

endpackage

// ===== src/rgb_to_hsl_pixel_converter.sv =====
// Top level of the RGB to HSL converter: front stage, item queue, divider pipeline.
// Depends on rhsl_pkg, rhsl_front, rhsl_queue and rhsl_back.
//
//   channel   valid         stall         payload
//   input     color_valid   color_stall   color_word
//   output    hsl_valid     hsl_stall     hue, saturation, lightness
//
// Takes one item per cycle unless output stalls back up; path: one front
// register, one queue slot, 18 divider stages (quotient bits from stage 1 on).
// Reset is asynchronous and active low; it clears valid bits and queue pointers.
// An output stall freezes the divider pipeline; the queue and front stage keep
// taking items until the queue fills.
module rgb_to_hsl_pixel_converter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        color_valid,
    output logic        color_stall,
    input  logic [31:0] color_word,
    output logic        hsl_valid,
    input  logic        hsl_stall,
    output logic [14:0] hue,
    output logic [15:0] saturation,
    output logic [8:0]  lightness
);
    import rhsl_pkg::*;

    logic       front_valid;
    logic       front_stall;
    rhsl_work_t front_item;
    logic       queue_valid;
    logic       queue_stall;
    rhsl_work_t queue_item;

    rhsl_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .color_valid (color_valid),
        .color_stall (color_stall),
        .color_word  (color_word),
        .work_valid  (front_valid),
        .work_stall  (front_stall),
        .work        (front_item)
    );

    rhsl_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (front_valid),
        .wr_stall (front_stall),
        .wr_item  (front_item),
        .rd_valid (queue_valid),
        .rd_stall (queue_stall),
        .rd_item  (queue_item)
    );

    rhsl_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .work_valid (queue_valid),
        .work_stall (queue_stall),
        .work       (queue_item),
        .hsl_valid  (hsl_valid),
        .hsl_stall  (hsl_stall),
        .hue        (hue),
        .saturation (saturation),
        .lightness  (lightness)
    );

`ifndef SYNTH
    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        hsl_valid |-> (hue < HUE_FULL))
        else $error("hue out of range");

    a_grey_hue: assert property (@(posedge clk) disable iff (!rst_n)
        (hsl_valid && saturation == 16'd0) |-> (hue == 15'd0))
        else $error("grey item with nonzero hue");

    a_black_white: assert property (@(posedge clk) disable iff (!rst_n)
        (hsl_valid && (lightness == 9'd0 || lightness == 9'd510)) |-> (saturation == 16'd0))
        else $error("black or white item with nonzero saturation");

    a_queue_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (queue_stall && queue_valid) |=> queue_valid)
        else $error("queue dropped a held item");
`endif

endmodule

// ===== src/rhsl_front.sv =====
// Front stage: split the color word, find max/min, and form the hue numerator
// and the saturation divisor. Depends on rhsl_pkg.
module rhsl_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                color_valid,
    output logic                color_stall,
    input  logic [31:0]         color_word,
    output logic                work_valid,
    input  logic                work_stall,
    output rhsl_pkg::rhsl_work_t work
);
    import rhsl_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    rhsl_work_t work_reg;
    rhsl_work_t work_next;
    logic       load;

    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  mx;
    logic [7:0]  mn;
    logic [7:0]  d;
    logic [8:0]  sum;
    logic [10:0] d11;
    logic [10:0] r11;
    logic [10:0] g11;
    logic [10:0] b11;
    logic [10:0] num;

    assign r = color_word[7:0];
    assign g = color_word[15:8];
    assign b = color_word[23:16];

    always_comb
    begin
        mx = r;
        mn = r;
        if (g > mx)
        begin
            mx = g;
        end
        if (b > mx)
        begin
            mx = b;
        end
        if (g < mn)
        begin
            mn = g;
        end
        if (b < mn)
        begin
            mn = b;
        end
    end

    assign d   = mx - mn;
    assign sum = {1'b0, mx} + {1'b0, mn};
    assign d11 = {3'b0, d};
    assign r11 = {3'b0, r};
    assign g11 = {3'b0, g};
    assign b11 = {3'b0, b};

    always_comb
    begin
        if (r == mn)
        begin
            num = (d11 << 1) + d11 + b11 - g11;
        end
        else if (g == mn)
        begin
            num = (d11 << 2) + d11 + r11 - b11;
        end
        else
        begin
            num = d11 + g11 - r11;
        end
    end

    assign color_stall = valid_reg && work_stall;
    assign load        = !color_stall;

    always_comb
    begin
        work_next.d   = d;
        work_next.sum = sum;
        work_next.num = num;
        work_next.div = (sum <= 9'd255) ? sum[7:0] : 8'(9'd510 - sum);
        valid_next    = load ? color_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            work_reg <= work_next;
        end
    end

    assign work_valid = valid_reg;
    assign work       = work_reg;

endmodule

// ===== src/rhsl_queue.sv =====
// Two-entry item queue between the front stage and the divider pipeline.
// Depends on rhsl_pkg.
module rhsl_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_valid,
    output logic                wr_stall,
    input  rhsl_pkg::rhsl_work_t wr_item,
    output logic                rd_valid,
    input  logic                rd_stall,
    output rhsl_pkg::rhsl_work_t rd_item
);
    import rhsl_pkg::*;

    rhsl_work_t mem_reg [0:1];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign wr_stall = (count_reg == 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign push     = wr_valid && !wr_stall;
    assign pop      = rd_valid && !rd_stall;
    assign rd_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// ===== src/rhsl_back.sv =====
// Back end: pipelined restoring dividers for hue and saturation, one quotient
// bit per step stage, then wrap, clamp and grey zeroing. Depends on rhsl_pkg.
module rhsl_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                work_valid,
    output logic                work_stall,
    input  rhsl_pkg::rhsl_work_t work,
    output logic                hsl_valid,
    input  logic                hsl_stall,
    output logic [14:0]         hue,
    output logic [15:0]         saturation,
    output logic [8:0]          lightness
);
    import rhsl_pkg::*;

    logic        vld_reg      [0:STAGES-1];
    logic        vld_next     [0:STAGES-1];
    logic [7:0]  hue_rem_reg  [0:STAGES-1];
    logic [7:0]  hue_rem_next [0:STAGES-1];
    logic [14:0] hue_sh_reg   [0:STAGES-1];
    logic [14:0] hue_sh_next  [0:STAGES-1];
    logic [7:0]  sat_rem_reg  [0:STAGES-1];
    logic [7:0]  sat_rem_next [0:STAGES-1];
    logic [16:0] sat_sh_reg   [0:STAGES-1];
    logic [16:0] sat_sh_next  [0:STAGES-1];
    logic [7:0]  d_reg        [0:STAGES-1];
    logic [7:0]  div_reg      [0:STAGES-1];
    logic [8:0]  sum_reg      [0:STAGES-1];

    logic        advance;
    logic [22:0] hue_num;
    logic [14:0] hue_q;

    assign advance    = !vld_reg[STAGES-1] || !hsl_stall;
    assign work_stall = !advance;
    assign hue_num    = {work.num, 12'b0} - {4'b0, work.num, 8'b0};

    always_comb
    begin
        vld_next[0]     = work_valid;
        hue_rem_next[0] = hue_num[22:15];
        hue_sh_next[0]  = hue_num[14:0];
        sat_rem_next[0] = {1'b0, work.d[7:1]};
        sat_sh_next[0]  = {work.d[0], 16'b0};
    end

    for (genvar k = 0; k < SAT_STEPS; k++)
    begin : g_step
        logic [8:0] ht;
        logic [8:0] st;
        logic       hb;
        logic       sb;

        always_comb
        begin
            ht = {hue_rem_reg[k], hue_sh_reg[k][14]};
            hb = (ht >= {1'b0, d_reg[k]});
            st = {sat_rem_reg[k], sat_sh_reg[k][16]};
            sb = (st >= {1'b0, div_reg[k]});
            vld_next[k+1] = vld_reg[k];
            if (k < HUE_STEPS)
            begin
                hue_rem_next[k+1] = hb ? 8'(ht - {1'b0, d_reg[k]}) : ht[7:0];
                hue_sh_next[k+1]  = {hue_sh_reg[k][13:0], hb};
            end
            else
            begin
                hue_rem_next[k+1] = hue_rem_reg[k];
                hue_sh_next[k+1]  = hue_sh_reg[k];
            end
            sat_rem_next[k+1] = sb ? 8'(st - {1'b0, div_reg[k]}) : st[7:0];
            sat_sh_next[k+1]  = {sat_sh_reg[k][15:0], sb};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STAGES; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (advance)
        begin
            for (int i = 0; i < STAGES; i++)
            begin
                vld_reg[i] <= vld_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < STAGES; i++)
            begin
                hue_rem_reg[i] <= hue_rem_next[i];
                hue_sh_reg[i]  <= hue_sh_next[i];
                sat_rem_reg[i] <= sat_rem_next[i];
                sat_sh_reg[i]  <= sat_sh_next[i];
            end
            d_reg[0]   <= work.d;
            div_reg[0] <= work.div;
            sum_reg[0] <= work.sum;
            for (int i = 1; i < STAGES; i++)
            begin
                d_reg[i]   <= d_reg[i-1];
                div_reg[i] <= div_reg[i-1];
                sum_reg[i] <= sum_reg[i-1];
            end
        end
    end

    assign hue_q     = hue_sh_reg[STAGES-1];
    assign hsl_valid = vld_reg[STAGES-1];
    assign lightness = sum_reg[STAGES-1];

    always_comb
    begin
        if (d_reg[STAGES-1] == 8'd0)
        begin
            hue        = 15'd0;
            saturation = 16'd0;
        end
        else
        begin
            hue        = (hue_q >= HUE_FULL) ? 15'(hue_q - HUE_FULL) : hue_q;
            saturation = sat_sh_reg[STAGES-1][16] ? SAT_MAX : sat_sh_reg[STAGES-1][15:0];
        end
    end

endmodule
